/* rtl/core/pfc_pkg.sv */
`default_nettype none

package pfc_pkg;

  // Square geometry and letter coding
  localparam int unsigned Side    = 5;
  localparam int unsigned LetterW = 5;
  localparam int unsigned RowW    = Side * LetterW;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgAddrW = 3;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [Side-1:0]    sel_t;

  // Letter i is looked up as letter j
  localparam letter_t CodeI = letter_t'(8);
  localparam letter_t CodeJ = letter_t'(9);

  // Key square: row r, column c at bits 5c+4..5c of row r
  typedef logic [Side-1:0][RowW-1:0] key_t;

  // Match map: [row][col]
  typedef logic [Side-1:0][Side-1:0] match_t;

  // Location of one letter in the square
  typedef struct packed {
    logic found;
    idx_t row;
    idx_t col;
  } pos_t;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    RegKeyRow0  = 3'd0,
    RegKeyRow1  = 3'd1,
    RegKeyRow2  = 3'd2,
    RegKeyRow3  = 3'd3,
    RegKeyRow4  = 3'd4,
    RegDecrypt  = 3'd5
  } cfg_reg_e;

  // Step one place forward or back, wrapping around the side
  function automatic idx_t wrap_step(idx_t i, logic back);
    idx_t r;
    if (back) begin
      r = (i == '0) ? idx_t'(Side - 1) : idx_t'(i - idx_t'(1));
    end else begin
      r = (i == idx_t'(Side - 1)) ? '0 : idx_t'(i + idx_t'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pfc_find.sv */
`default_nettype none

// Picks the last match in row-major order out of a match map.
module pfc_find (
  input  pfc_pkg::match_t match_i,
  output pfc_pkg::pos_t   pos_o
);
  import pfc_pkg::*;

  sel_t row_hit;
  idx_t row_sel;
  idx_t col_sel;

  // Highest row holding a match
  always_comb begin
    row_sel = '0;
    for (int r = 0; r < Side; r++) begin
      row_hit[r] = |match_i[r];
      if (row_hit[r]) begin
        row_sel = idx_t'(r);
      end
    end
  end

  // Highest column matching within that row
  always_comb begin
    col_sel = '0;
    for (int c = 0; c < Side; c++) begin
      for (int r = 0; r < Side; r++) begin
        if (match_i[r][c] && (row_sel == idx_t'(r))) begin
          col_sel = idx_t'(c);
        end
      end
    end
  end

  assign pos_o.found = |row_hit;
  assign pos_o.row   = row_sel;
  assign pos_o.col   = col_sel;

endmodule

`default_nettype wire

/* rtl/core/playfair_digraph_cipher.sv */
`default_nettype none

// Playfair digraph substitution, one digraph per beat.
//
// Input stream: one beat carries a digraph, two letters coded 0 (a) to 25 (z).
// Output stream: one beat per input beat, in order, with the two substituted
// letters and a tuser flag set when either letter is not in the key square;
// the input letters then pass through unchanged.
// Configuration: five key rows and the decrypt flag are written through cfg_we_i /
// cfg_addr_i / cfg_wdata_i by the user, only while no beat is in flight (not enforced).
//
// The pipeline has four register stages: match, locate, shift/select, cell
// readout. Throughput is one digraph per cycle while the receiver keeps up. Each
// stage moves on when it is empty or the next one moves, so a stalled receiver
// holds the last stage and bubbles further up still fill; s_axis_tready drops
// only once all four stages are full.
// Reset clears the key square to zero, selects encryption and empties the
// pipeline.
module playfair_digraph_cipher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [pfc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pfc_pkg::RowW-1:0]   cfg_wdata_i,
  // input digraph stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [4:0] first_letter, [9:5] second_letter
  // output digraph stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [4:0] first_out, [9:5] second_out
  output logic                       m_axis_tuser   // [0] letter_missing
);
  import pfc_pkg::*;

  // Configuration registers
  key_t key_q;
  logic decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegKeyRow0: key_q[0]  <= cfg_wdata_i;
        RegKeyRow1: key_q[1]  <= cfg_wdata_i;
        RegKeyRow2: key_q[2]  <= cfg_wdata_i;
        RegKeyRow3: key_q[3]  <= cfg_wdata_i;
        RegKeyRow4: key_q[4]  <= cfg_wdata_i;
        RegDecrypt: decrypt_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its contents move on
  logic v1_q, v2_q, v3_q, v4_q;
  logic free1, free2, free3, free4;

  assign free4 = !v4_q || m_axis_tready;
  assign free3 = !v3_q || free4;
  assign free2 = !v2_q || free3;
  assign free1 = !v1_q || free2;
  assign s_axis_tready = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free1) v1_q <= s_axis_tvalid;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
    end
  end

  // Stage 1: compare both letters against every cell
  letter_t in_a, in_b, key_a, key_b;
  match_t  ma_d, mb_d;
  match_t  ma1_q, mb1_q;
  letter_t a1_q, b1_q;

  assign in_a  = s_axis_tdata[LetterW-1:0];
  assign in_b  = s_axis_tdata[2*LetterW-1:LetterW];
  assign key_a = (in_a == CodeI) ? CodeJ : in_a;
  assign key_b = (in_b == CodeI) ? CodeJ : in_b;

  always_comb begin
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        ma_d[r][c] = (key_q[r][c*LetterW +: LetterW] == key_a);
        mb_d[r][c] = (key_q[r][c*LetterW +: LetterW] == key_b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free1) begin
      ma1_q <= ma_d;
      mb1_q <= mb_d;
      a1_q  <= in_a;
      b1_q  <= in_b;
    end
  end

  // Stage 2: reduce match maps to positions
  pos_t    pa_d, pb_d;
  pos_t    pa2_q, pb2_q;
  letter_t a2_q, b2_q;

  pfc_find u_find_a (
    .match_i (ma1_q),
    .pos_o   (pa_d)
  );

  pfc_find u_find_b (
    .match_i (mb1_q),
    .pos_o   (pb_d)
  );

  always_ff @(posedge clk_i) begin
    if (free2) begin
      pa2_q <= pa_d;
      pb2_q <= pb_d;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
    end
  end

  // Stage 3: apply the row, column or rectangle rule
  idx_t    ra_d, ca_d, rb_d, cb_d;
  sel_t    rsa_q, csa_q, rsb_q, csb_q;
  logic    miss3_q;
  letter_t a3_q, b3_q;

  always_comb begin
    ra_d = pa2_q.row;
    rb_d = pb2_q.row;
    ca_d = pb2_q.col;
    cb_d = pa2_q.col;
    if (pa2_q.row == pb2_q.row) begin
      ca_d = wrap_step(pa2_q.col, decrypt_q);
      cb_d = wrap_step(pb2_q.col, decrypt_q);
    end else if (pa2_q.col == pb2_q.col) begin
      ra_d = wrap_step(pa2_q.row, decrypt_q);
      rb_d = wrap_step(pb2_q.row, decrypt_q);
      ca_d = pa2_q.col;
      cb_d = pb2_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free3) begin
      rsa_q   <= sel_t'(1) << ra_d;
      csa_q   <= sel_t'(1) << ca_d;
      rsb_q   <= sel_t'(1) << rb_d;
      csb_q   <= sel_t'(1) << cb_d;
      miss3_q <= !(pa2_q.found && pb2_q.found);
      a3_q    <= a2_q;
      b3_q    <= b2_q;
    end
  end

  // Stage 4: read the selected cells into the output register
  letter_t oa_d, ob_d;
  letter_t oa4_q, ob4_q;
  logic    miss4_q;

  always_comb begin
    oa_d = '0;
    ob_d = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (rsa_q[r] && csa_q[c]) oa_d = oa_d | key_q[r][c*LetterW +: LetterW];
        if (rsb_q[r] && csb_q[c]) ob_d = ob_d | key_q[r][c*LetterW +: LetterW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free4) begin
      oa4_q   <= miss3_q ? a3_q : oa_d;
      ob4_q   <= miss3_q ? b3_q : ob_d;
      miss4_q <= miss3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {6'd0, ob4_q, oa4_q};
  assign m_axis_tuser  = miss4_q;

  // upper input bits carry nothing
  logic unused_in;
  assign unused_in = ^s_axis_tdata[15:2*LetterW];

endmodule

`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  // Run limits
  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 8;
  localparam int MaxGap      = 40;
  localparam int RandomItems = 150;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [CfgAddrW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgAddrW-1:0] RegSpareHi = 3'd7;

  // One output beat as the checker sees it
  typedef struct packed {
    letter_t first_out;
    letter_t second_out;
    logic    letter_missing;
  } cipher_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [RowW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;  // [4:0] first_letter, [9:5] second_letter
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;       // [4:0] first_out, [9:5] second_out
  logic                m_axis_tuser;       // [0] letter_missing

  // Shadow copy of the key square and mode
  key_t key_sq = '0;
  logic decrypt_on = 1'b0;

  cipher_beat_t cipher_q[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;
  int mismatches = 0;
  int digraphs_sent = 0;
  int results_checked = 0;
  int key_settings = 0;

  // Textbook square, j standing in for i
  letter_t classic_cells [25] = '{15, 11, 0, 24, 5,
                                  9, 17, 4, 23, 12,
                                  1, 2, 3, 6, 7,
                                  10, 13, 14, 16, 18,
                                  19, 20, 21, 22, 25};

  playfair_digraph_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Square lookup helpers
  function automatic letter_t cell_at(int r, int c);
    return key_sq[r][c*LetterW +: LetterW];
  endfunction

  function automatic key_t cells_to_key(input letter_t cells [25]);
    key_t k;
    k = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        k[r][c*LetterW +: LetterW] = cells[r*Side + c];
      end
    end
    return k;
  endfunction

  // Expected substitution for one digraph under the current square and mode
  function automatic cipher_beat_t playfair_predict(letter_t a, letter_t b);
    letter_t la, lb;
    bit fa, fb;
    int ra, ca, rb, cb, step, n;
    cipher_beat_t res;
    n = Side;
    la = (a == CodeI) ? CodeJ : a;
    lb = (b == CodeI) ? CodeJ : b;
    fa = 1'b0;
    fb = 1'b0;
    ra = 0; ca = 0; rb = 0; cb = 0;
    // last match in row-major order wins
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        if (cell_at(r, c) == la) begin
          fa = 1'b1; ra = r; ca = c;
        end
        if (cell_at(r, c) == lb) begin
          fb = 1'b1; rb = r; cb = c;
        end
      end
    end
    step = decrypt_on ? n - 1 : 1;
    res.letter_missing = 1'b0;
    if (!fa || !fb) begin
      res.first_out = a;
      res.second_out = b;
      res.letter_missing = 1'b1;
    end else if (ra == rb) begin
      res.first_out = cell_at(ra, (ca + step) % n);
      res.second_out = cell_at(rb, (cb + step) % n);
    end else if (ca == cb) begin
      res.first_out = cell_at((ra + step) % n, ca);
      res.second_out = cell_at((rb + step) % n, cb);
    end else begin
      res.first_out = cell_at(ra, cb);
      res.second_out = cell_at(rb, ca);
    end
    return res;
  endfunction

  // Random square: all letters but i, optionally with a few cells overwritten
  function automatic key_t shuffled_square(bit mutate);
    letter_t cells [25];
    letter_t tmp;
    int n, j;
    n = 0;
    for (int l = 0; l < 26; l++) begin
      if (l != CodeI) begin
        cells[n] = letter_t'(l);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = cells[i];
      cells[i] = cells[j];
      cells[j] = tmp;
    end
    if (mutate) begin
      repeat ($urandom_range(4, 1)) cells[$urandom_range(24)] = letter_t'($urandom_range(31));
    end
    return cells_to_key(cells);
  endfunction

  // Mostly real letters, sometimes the unused codes 26..31
  function automatic letter_t random_letter();
    if ($urandom_range(9) == 0) return letter_t'($urandom_range(31));
    return letter_t'($urandom_range(25));
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // Register write; write enable stays up for back-to-back writes
  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [RowW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (addr <= RegKeyRow4) begin
      key_sq[addr] = data;
    end else if (addr == RegDecrypt) begin
      decrypt_on = data[0];
    end
  endtask

  task automatic program_key(input key_t k, input logic dec);
    logic [RowW-1:0] mode_word;
    mode_word = RowW'($urandom);
    mode_word[0] = dec;
    cfg_write(RegKeyRow0, k[0]);
    cfg_write(RegKeyRow1, k[1]);
    cfg_write(RegKeyRow2, k[2]);
    cfg_write(RegKeyRow3, k[3]);
    cfg_write(RegKeyRow4, k[4]);
    cfg_write(RegDecrypt, mode_word);
    cfg_write(RegSpareLo, RowW'($urandom));
    cfg_write(RegSpareHi, RowW'($urandom));
    cfg_we_i <= 1'b0;
    key_settings++;
  endtask

  // Offer one digraph beat, with a random gap first; tvalid stays up after
  task automatic send_digraph(input letter_t a, input letter_t b);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cipher_q.push_back(playfair_predict(a, b));
    digraphs_sent++;
  endtask

  // Stop sending and wait until every expected beat is out
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: long hold-off when requested, else random stalls
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Output checker
  always @(posedge clk_i) begin : check_results
    cipher_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.first_out = m_axis_tdata[4:0];
      got.second_out = m_axis_tdata[9:5];
      got.letter_missing = m_axis_tuser;
      results_checked++;
      if (cipher_q.size() == 0) begin
        report_mismatch("output beat with none expected", -1, got.first_out);
      end else begin
        want = cipher_q.pop_front();
        if (got.first_out !== want.first_out)
          report_mismatch("first_out", want.first_out, got.first_out);
        if (got.second_out !== want.second_out)
          report_mismatch("second_out", want.second_out, got.second_out);
        if (got.letter_missing !== want.letter_missing)
          report_mismatch("letter_missing", want.letter_missing, got.letter_missing);
      end
    end
  end

  // Square left at reset: every cell is a
  task automatic test_reset_square();
    send_digraph(0, 0);
    send_digraph(0, 25);
    send_digraph(8, 0);
    drain_pipeline();
  endtask

  // Textbook square: row, column, rectangle, i as j, equal letters, absent codes
  task automatic test_known_square();
    program_key(cells_to_key(classic_cells), 1'b0);
    send_digraph(15, 0);
    send_digraph(5, 15);
    send_digraph(15, 19);
    send_digraph(7, 8);
    send_digraph(4, 4);
    send_digraph(8, 9);
    send_digraph(0, 25);
    send_digraph(25, 0);
    send_digraph(26, 0);
    send_digraph(0, 31);
    send_digraph(31, 31);
    drain_pipeline();
    program_key(cells_to_key(classic_cells), 1'b1);
    send_digraph(15, 0);
    send_digraph(5, 15);
    send_digraph(15, 19);
    send_digraph(7, 8);
    send_digraph(31, 0);
    drain_pipeline();
  endtask

  // Squares with i stored, duplicates, high codes; then every cell 31
  task automatic test_odd_squares();
    letter_t cells [25];
    cells = classic_cells;
    cells[0] = CodeI;
    cells[24] = 0;
    cells[18] = 31;
    program_key(cells_to_key(cells), 1'b0);
    send_digraph(8, 9);
    send_digraph(0, 11);
    send_digraph(15, 0);
    send_digraph(31, 25);
    send_digraph(31, 0);
    drain_pipeline();
    program_key('1, 1'b1);
    send_digraph(31, 31);
    send_digraph(30, 31);
    drain_pipeline();
  endtask

  // Random traffic across the idle/stall phases, clean and damaged squares
  task automatic test_random_traffic();
    int tx_pcts [4];
    int rx_pcts [4];
    tx_pcts = '{0, 88, 0, 34};
    rx_pcts = '{0, 0, 88, 34};
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pcts[p];
      rx_stall_pct = rx_pcts[p];
      for (int s = 0; s < 2; s++) begin
        program_key(shuffled_square(s == 1), 1'($urandom_range(1)));
        repeat (RandomItems) send_digraph(random_letter(), random_letter());
        drain_pipeline();
      end
    end
  endtask

  // Receiver holds off while beats keep coming, then random sender gaps and receiver stalls
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    program_key(shuffled_square(1'b0), 1'($urandom_range(1)));
    rx_hold_left = 80;
    repeat (40) send_digraph(random_letter(), random_letter());
    drain_pipeline();
    tx_idle_pct = 34;
    rx_stall_pct = 34;
    repeat (20) send_digraph(random_letter(), random_letter());
    drain_pipeline();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_square();
    test_known_square();
    test_odd_squares();
    test_random_traffic();
    test_backpressure();
    $display("Sent %0d digraphs, checked %0d output beats over %0d key settings",
             digraphs_sent, results_checked, key_settings);
    $display("Covered encrypt/decrypt, absent letters, idle/stall phases, full backpressure");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LimitCycles * 2);
    $display("Timeout with %0d beats outstanding", cipher_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
